// ===== src/sorted_key_bitmap_table_defines.svh =====
// assertion macros for the sorted key bitmap table
// used by the top level, no other dependencies
`ifndef SORTED_KEY_BITMAP_TABLE_DEFINES_SVH
`define SORTED_KEY_BITMAP_TABLE_DEFINES_SVH

// same-cycle implication
`define SKBT_ASSERT_SAME(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SKBT_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/skbt_pkg.sv =====
// shared types and constants for the sorted key bitmap table
// no dependencies
package skbt_pkg;

  localparam int KEY_W     = 31;
  localparam int NODE_W    = 11;
  localparam int WORD_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 8;

  localparam logic OP_MARK = 1'b0;
  localparam logic OP_TEST = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic              op;
    logic [KEY_W-1:0]  key;
    logic [NODE_W-1:0] node;
  } req_t;

endpackage

// ===== src/skbt_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module skbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sorted_key_bitmap_table.sv =====
// sorted key table with per-key node bitmaps: mark and test requests
// depends on skbt_pkg, skbt_ram and sorted_key_bitmap_table_defines.svh
// a node out of range goes straight to the result; otherwise the keys are scanned in order
// insert at p of n keys: entries from p up move one place, then each bitmap word of the slot
//   ((MAX_NODES+31)/32 words) is cleared, with a nonzero node's bit set in its word
// one request in flight, next taken after the result loads; reset clears count and control only
`include "sorted_key_bitmap_table_defines.svh"

module sorted_key_bitmap_table
  import skbt_pkg::*;
#(
  parameter int MAX_KEYS  = 64,
  parameter int MAX_NODES = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // key_id[30:0], node_number[41:31], zero fill
  input  logic [0:0]           s_tuser,   // operation[0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // hit[0], status[2:1], zero fill
);

  localparam int WORDS    = (MAX_NODES + 31) / 32;
  localparam int BM_DEPTH = MAX_KEYS * WORDS;
  localparam int KI_W     = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int SLOT_W   = KI_W;
  localparam int KW       = KEY_W + SLOT_W;
  localparam int BM_AW    = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;
  localparam int WC_W     = (WORDS > 1) ? $clog2(WORDS) : 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_ADDR    = 3'd2;
  localparam logic [2:0] S_RESOLVE = 3'd3;
  localparam logic [2:0] S_BM_WAIT = 3'd4;
  localparam logic [2:0] S_SHIFT   = 3'd5;
  localparam logic [2:0] S_CLEAR   = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0]          state;
  req_t                req;
  req_t                in_req;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    ptr;
  logic [CNT_W-1:0]    ptr_dec;
  logic                pend;
  logic [CNT_W-1:0]    pend_ptr;
  logic [CNT_W-1:0]    pos;
  logic                found;
  logic [SLOT_W-1:0]   slot;
  logic [BM_AW-1:0]    bm_base;
  logic [WC_W-1:0]     clr_cnt;
  logic                clr_last;
  logic                res_hit;
  logic [STATUS_W-1:0] res_status;

  logic [NODE_W-1:0]   node_m1;
  logic [5:0]          word_off;
  logic [4:0]          bit_sel;
  logic [WORD_W-1:0]   bit_mask;
  logic [BM_AW-1:0]    bm_word_addr;

  logic                key_we;
  logic [KI_W-1:0]     key_waddr;
  logic [KW-1:0]       key_wdata;
  logic [KI_W-1:0]     key_raddr;
  logic [KW-1:0]       key_rdata;
  logic [KEY_W-1:0]    rd_key;
  logic [SLOT_W-1:0]   rd_slot;

  logic                bm_we;
  logic [BM_AW-1:0]    bm_waddr;
  logic [WORD_W-1:0]   bm_wdata;
  logic [WORD_W-1:0]   bm_rdata;

  logic                out_load;

  always_comb begin
    in_req.op   = s_tuser[0];
    in_req.key  = s_tdata[KEY_W-1:0];
    in_req.node = s_tdata[KEY_W+NODE_W-1:KEY_W];
  end

  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  assign node_m1      = req.node - 1'b1;
  assign word_off     = node_m1[10:5];
  assign bit_sel      = node_m1[4:0];
  assign bit_mask     = WORD_W'(1) << bit_sel;
  assign bm_word_addr = bm_base + BM_AW'(word_off);
  assign clr_last     = (clr_cnt == WC_W'(WORDS - 1));
  assign ptr_dec      = ptr - 1'b1;
  assign rd_key       = key_rdata[KEY_W-1:0];
  assign rd_slot      = key_rdata[KW-1:KEY_W];

  // key ram access
  always_comb begin
    key_raddr = (state == S_SHIFT) ? ptr_dec[KI_W-1:0] : ptr[KI_W-1:0];
    key_we    = (state == S_SHIFT) && (pend || (ptr == pos));
    key_waddr = pend ? pend_ptr[KI_W-1:0] : pos[KI_W-1:0];
    key_wdata = pend ? key_rdata : {slot, req.key};
  end

  // bitmap ram access
  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = bm_word_addr;
    bm_wdata = bm_rdata | bit_mask;
    if (state == S_BM_WAIT && req.op == OP_MARK) begin
      bm_we = 1'b1;
    end else if (state == S_CLEAR) begin
      bm_we    = 1'b1;
      bm_waddr = bm_base + BM_AW'(clr_cnt);
      bm_wdata = ((req.node != '0) && (16'(word_off) == 16'(clr_cnt))) ? bit_mask : '0;
    end
  end

  skbt_ram #(.WIDTH(KW), .DEPTH(MAX_KEYS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  skbt_ram #(.WIDTH(WORD_W), .DEPTH(BM_DEPTH)) u_bm_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_word_addr),
    .rdata (bm_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req     <= in_req;
            res_hit <= 1'b0;
            ptr     <= '0;
            pend    <= 1'b0;
            if (32'(in_req.node) > MAX_NODES) begin
              res_status <= ST_RANGE;
              state      <= S_DONE;
            end else begin
              res_status <= ST_OK;
              state      <= S_SCAN;
            end
          end
        end
        // ordered scan, one read per cycle, compare on the returned entry
        S_SCAN: begin
          if (pend && (rd_key >= req.key)) begin
            pos   <= pend_ptr;
            found <= (rd_key == req.key);
            slot  <= (rd_key == req.key) ? rd_slot : count[SLOT_W-1:0];
            pend  <= 1'b0;
            state <= S_ADDR;
          end else if (ptr < count) begin
            ptr      <= ptr + 1'b1;
            pend     <= 1'b1;
            pend_ptr <= ptr;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            pos   <= count;
            found <= 1'b0;
            slot  <= count[SLOT_W-1:0];
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          bm_base <= BM_AW'(slot * WORDS);
          ptr     <= count;
          pend    <= 1'b0;
          state   <= S_RESOLVE;
        end
        S_RESOLVE: begin
          if (found) begin
            res_hit <= 1'b1;
            state   <= (req.node == '0) ? S_DONE : S_BM_WAIT;
          end else if (req.op == OP_TEST) begin
            state <= S_DONE;
          end else if (count == CNT_W'(MAX_KEYS)) begin
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else begin
            state <= S_SHIFT;
          end
        end
        S_BM_WAIT: begin
          if (req.op == OP_TEST) begin
            res_hit <= bm_rdata[bit_sel];
          end
          state <= S_DONE;
        end
        // move later entries up one place, then place the new key
        S_SHIFT: begin
          if (ptr > pos) begin
            ptr      <= ptr_dec;
            pend     <= 1'b1;
            pend_ptr <= ptr;
          end else begin
            pend <= 1'b0;
          end
          if ((ptr == pos) && !pend) begin
            clr_cnt <= '0;
            state   <= S_CLEAR;
          end
        end
        // fresh bitmap slot, node bit folded into its word
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_last) begin
            count <= count + 1'b1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            m_tdata <= {{(M_TDATA_W-STATUS_W-1){1'b0}}, res_status, res_hit};
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SKBT_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(MAX_KEYS), "entry count above capacity")
  `SKBT_ASSERT_NEXT(a_count_step, clk, rst, (state == S_CLEAR) && clr_last, count == $past(count) + 1'b1, "entry count not advanced on insert")
  `SKBT_ASSERT_SAME(a_key_write_bound, clk, rst, key_we, CNT_W'(key_waddr) <= count, "key write beyond held entries")
  `SKBT_ASSERT_SAME(a_full_status, clk, rst, m_tvalid && (m_tdata[2:1] == ST_FULL), count == CNT_W'(MAX_KEYS), "full status with room left")
  `SKBT_ASSERT_NEXT(a_result_load, clk, rst, out_load, m_tvalid && (state == S_IDLE), "result not presented after completion")

endmodule
